// ===== hdl/can_arb_pkg.sv =====
// Shared types and codes for the CAN bus arbitration controller.
// Holds the table entry layout, result word layout, op, kind and wake-up codes.
// No dependencies.
`default_nettype none
package can_arb_pkg;

    localparam int ID_W   = 29;
    localparam int NODE_W = 5;
    localparam int TIME_W = 32;
    localparam int BITS_W = 8;
    localparam int OP_W   = 4;
    localparam int KIND_W = 4;
    localparam int WAKE_W = 3;
    localparam int PEND_W = 4;

    localparam logic [BITS_W-1:0] ACK_SLOT_BITS    = 8'd11;
    localparam logic [BITS_W-1:0] ERROR_FRAME_BITS = 8'd12;
    localparam logic [BITS_W-1:0] NO_POS_DELAY     = 8'd255;
    localparam logic [PEND_W-1:0] PEND_MAX         = 4'd15;

    // input ops
    localparam logic [OP_W-1:0] OP_SIGNIN     = 4'd0;
    localparam logic [OP_W-1:0] OP_SIGNOUT    = 4'd1;
    localparam logic [OP_W-1:0] OP_ACK        = 4'd2;
    localparam logic [OP_W-1:0] OP_ERROR      = 4'd3;
    localparam logic [OP_W-1:0] OP_FRAME      = 4'd4;
    localparam logic [OP_W-1:0] OP_IDLE       = 4'd5;
    localparam logic [OP_W-1:0] OP_WAKE       = 4'd6;
    localparam logic [OP_W-1:0] OP_COMPLETE   = 4'd7;
    localparam logic [OP_W-1:0] OP_ERRRES     = 4'd8;
    localparam logic [OP_W-1:0] OP_ERRRESDONE = 4'd9;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_GRANT     = 4'd0;
    localparam logic [KIND_W-1:0] KIND_FAILED    = 4'd1;
    localparam logic [KIND_W-1:0] KIND_COMPLETE  = 4'd2;
    localparam logic [KIND_W-1:0] KIND_SCHEDULE  = 4'd3;
    localparam logic [KIND_W-1:0] KIND_FWDFRAME  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_FWDERROR  = 4'd5;
    localparam logic [KIND_W-1:0] KIND_BUSIDLE   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_CONFLICT  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_TABLEFULL = 4'd8;

    // scheduled wake-up ops
    localparam logic [WAKE_W-1:0] WK_IDLE       = 3'd0;
    localparam logic [WAKE_W-1:0] WK_WAKE       = 3'd1;
    localparam logic [WAKE_W-1:0] WK_COMPLETE   = 3'd2;
    localparam logic [WAKE_W-1:0] WK_ERRRES     = 3'd3;
    localparam logic [WAKE_W-1:0] WK_ERRRESDONE = 3'd4;

    // configuration register indexes
    localparam logic CFG_ERRORS_ENABLED = 1'b0;
    localparam logic CFG_ACK_ENABLED    = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [NODE_W-1:0] node;
        logic              rtr;
        logic              rs;
        logic [TIME_W-1:0] sit;
    } entry_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic              rm_en;
        logic [ID_W-1:0]   key_id;
        logic              use_rtr;
        logic              key_rtr;
    } cell_ctrl_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WAKE_W-1:0] wake;
        logic [BITS_W-1:0] delay;
        logic [NODE_W-1:0] node;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] sit;
        logic              rs;
    } result_t;

endpackage
`default_nettype wire

// ===== hdl/can_bus_arbitration_controller.sv =====
// One input word at a time: s_ready returns in the cycle after the last result of an item
// is flushed, and any m_ready stall holds the item back.
// Reset (aresetn low, synchronous): table empty, bus idle, ack received, state ok,
// no errors pending, errors_enabled 0, ack_enabled 1. No clearing pass.
// Depends on can_arb_pkg and can_arb_cell.
`default_nettype none
module can_bus_arbitration_controller #(
    parameter int TABLE_ENTRIES = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic                              cfg_index,
    input  wire logic                              cfg_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [can_arb_pkg::OP_W-1:0]      s_op,
    input  wire logic [can_arb_pkg::ID_W-1:0]      s_frame_id,
    input  wire logic [can_arb_pkg::NODE_W-1:0]    s_node_index,
    input  wire logic                              s_remote_request,
    input  wire logic                              s_was_resent,
    input  wire logic                              s_ack_bit,
    input  wire logic [can_arb_pkg::BITS_W-1:0]    s_error_position,
    input  wire logic [can_arb_pkg::BITS_W-1:0]    s_frame_bits,
    input  wire logic [can_arb_pkg::TIME_W-1:0]    s_time_now,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [can_arb_pkg::KIND_W-1:0]         m_kind,
    output logic [can_arb_pkg::WAKE_W-1:0]         m_wake_event,
    output logic [can_arb_pkg::BITS_W-1:0]         m_delay_bits,
    output logic [can_arb_pkg::NODE_W-1:0]         m_target_node,
    output logic [can_arb_pkg::ID_W-1:0]           m_result_id,
    output logic [can_arb_pkg::TIME_W-1:0]         m_grant_sign_in_time,
    output logic                                   m_grant_resent,
    output logic                                   m_last_result
);
    import can_arb_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_SI_A, S_SI_B, S_ER_A, S_ER_B, S_FR_A, S_FR_B,
        S_OP_A, S_OP_B, S_ARB_CHK, S_MIN, S_CONF, S_REMOVE,
        S_ARB_E1, S_ARB_E2, S_END, S_FIN
    } state_t;

    state_t state_reg;
    state_t ret_reg;

    // latched input word
    logic [OP_W-1:0]   op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [NODE_W-1:0] node_reg;
    logic              rtr_reg;
    logic              rs_reg;
    logic [BITS_W-1:0] epos_reg;
    logic [BITS_W-1:0] fbits_reg;
    logic [TIME_W-1:0] now_reg;

    // bus flags and configuration
    logic              errors_enabled_reg;
    logic              ack_enabled_reg;
    logic              bus_idle_reg;
    logic              ack_received_reg;
    logic              state_ok_reg;
    logic              err_latched_reg;
    logic [PEND_W-1:0] err_pend_reg;
    logic              pos_valid_reg;
    logic [BITS_W-1:0] pos_value_reg;
    logic [TIME_W-1:0] cur_sit_reg;
    logic [CW-1:0]     count_reg;

    // arbitration scratch
    logic [IW-1:0]     scan_idx_reg;
    logic [ID_W-1:0]   best_id_reg;
    logic [NODE_W-1:0] best_node_reg;
    logic              best_rs_reg;
    logic [TIME_W-1:0] best_sit_reg;
    logic [1:0]        switches_reg;

    // removal key
    logic [ID_W-1:0]   rm_id_reg;
    logic              rm_use_rtr_reg;
    logic              rm_rtr_reg;

    // staged and output result words
    logic              stg_valid_reg;
    result_t           stg_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    logic              out_last_reg;

    // cell chain
    cell_ctrl_t        ctrl;
    logic [TABLE_ENTRIES-1:0] c_valid;
    entry_t            c_data [TABLE_ENTRIES];
    logic [TABLE_ENTRIES:0]   c_shift;
    logic [TABLE_ENTRIES-1:0] c_ins;
    entry_t            ins_data;
    entry_t            scan_e;
    logic              any_match;

    logic              table_full;
    logic              arb_ok;
    logic              pend_clear;
    logic              pos_upd;
    logic [BITS_W-1:0] frame_delay;
    logic [IW-1:0]     last_idx;
    logic              scan_take;
    logic              conf_take;

    logic              emit_req;
    result_t           emit_data;
    logic              out_free;
    logic              can_emit;
    logic              emit_fire;
    logic              flush_fire;
    logic              adv;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);

    assign table_full  = (count_reg == CW'(TABLE_ENTRIES));
    assign pend_clear  = (err_pend_reg == '0);
    assign arb_ok      = (!errors_enabled_reg || pend_clear) &&
                         (!ack_enabled_reg || ack_received_reg) && state_ok_reg;
    assign pos_upd     = !pos_valid_reg || (pos_value_reg > epos_reg);
    assign frame_delay = !ack_enabled_reg ? fbits_reg :
                         (fbits_reg > ACK_SLOT_BITS) ? fbits_reg - ACK_SLOT_BITS : '0;
    assign last_idx    = IW'(count_reg - CW'(1));

    // build the chain
    assign ctrl = '{rm_en: (state_reg == S_REMOVE) && any_match, key_id: rm_id_reg,
                    use_rtr: rm_use_rtr_reg, key_rtr: rm_rtr_reg};
    assign ins_data = '{id: id_reg, node: node_reg, rtr: rtr_reg, rs: rs_reg, sit: now_reg};
    assign c_shift[0] = 1'b0;
    assign any_match  = c_shift[TABLE_ENTRIES];

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        logic   nbv;
        entry_t nbd;
        if (g == TABLE_ENTRIES - 1) begin : g_tail
            assign nbv = 1'b0;
            assign nbd = '0;
        end else begin : g_mid
            assign nbv = c_valid[g+1];
            assign nbd = c_data[g+1];
        end
        assign c_ins[g] = (state_reg == S_SI_A) && !table_full && (count_reg == CW'(g));
        can_arb_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .ins_en    (c_ins[g]),
            .ins_data  (ins_data),
            .shift_in  (c_shift[g]),
            .nb_valid  (nbv),
            .nb_data   (nbd),
            .q_valid   (c_valid[g]),
            .q_data    (c_data[g]),
            .shift_out (c_shift[g+1])
        );
    end

    // read one cell per scan cycle
    assign scan_e    = c_data[scan_idx_reg];
    assign scan_take = (scan_idx_reg == '0) || (scan_e.id < best_id_reg);
    assign conf_take = (scan_e.id == best_id_reg) && !scan_e.rtr &&
                       (scan_e.node != best_node_reg);

    // pick the result word each state wants to send
    always_comb begin
        emit_req  = 1'b0;
        emit_data = '{kind: KIND_GRANT, wake: WK_IDLE, delay: '0, node: node_reg,
                      id: id_reg, sit: '0, rs: 1'b0};
        case (state_reg)
            S_SI_A: begin
                emit_req = table_full;
                emit_data.kind = KIND_TABLEFULL;
            end
            S_SI_B: begin
                emit_req = bus_idle_reg;
                emit_data.kind  = KIND_SCHEDULE;
                emit_data.wake  = WK_WAKE;
                emit_data.delay = 8'd1;
            end
            S_ER_A: begin
                emit_req = !err_latched_reg;
                emit_data.kind  = KIND_SCHEDULE;
                emit_data.wake  = WK_ERRRES;
                emit_data.delay = ERROR_FRAME_BITS;
            end
            S_ER_B: begin
                emit_req = !pos_valid_reg;
                emit_data.kind  = KIND_FWDERROR;
                emit_data.delay = epos_reg;
            end
            S_FR_A: begin
                emit_req = 1'b1;
                emit_data.kind  = KIND_SCHEDULE;
                emit_data.delay = frame_delay;
            end
            S_FR_B: begin
                emit_req = 1'b1;
                emit_data.kind  = KIND_FWDFRAME;
                emit_data.delay = fbits_reg;
            end
            S_OP_A: begin
                case (op_reg)
                    OP_IDLE: begin
                        emit_req = pend_clear || !errors_enabled_reg;
                        if (!ack_enabled_reg) begin
                            emit_data.kind = KIND_COMPLETE;
                        end else if (ack_received_reg) begin
                            emit_data.kind  = KIND_SCHEDULE;
                            emit_data.wake  = WK_COMPLETE;
                            emit_data.delay = ACK_SLOT_BITS;
                        end else begin
                            emit_data.kind = KIND_FAILED;
                        end
                    end
                    OP_COMPLETE: begin
                        emit_req = 1'b1;
                        emit_data.kind = KIND_COMPLETE;
                    end
                    OP_ERRRES: begin
                        emit_req = 1'b1;
                        emit_data.kind  = KIND_SCHEDULE;
                        emit_data.wake  = WK_ERRRESDONE;
                        emit_data.delay = pos_valid_reg ? pos_value_reg : NO_POS_DELAY;
                    end
                    default: emit_req = 1'b0;
                endcase
            end
            S_OP_B: begin
                emit_req = 1'b1;
                emit_data.sit = cur_sit_reg;
                emit_data.rs  = 1'b1;
            end
            S_ARB_CHK: begin
                emit_req = arb_ok && (count_reg == '0);
                emit_data = '{kind: KIND_BUSIDLE, wake: WK_IDLE, delay: '0, node: '0,
                              id: '0, sit: '0, rs: 1'b0};
            end
            S_ARB_E1: begin
                emit_req = switches_reg[1];
                emit_data = '{kind: KIND_CONFLICT, wake: WK_IDLE, delay: '0,
                              node: best_node_reg, id: best_id_reg, sit: '0, rs: 1'b0};
            end
            S_ARB_E2: begin
                emit_req = 1'b1;
                emit_data = '{kind: KIND_GRANT, wake: WK_IDLE, delay: '0,
                              node: best_node_reg, id: best_id_reg, sit: best_sit_reg,
                              rs: best_rs_reg};
            end
            default: emit_req = 1'b0;
        endcase
    end

    assign out_free   = !out_valid_reg || m_ready;
    assign can_emit   = !stg_valid_reg || out_free;
    assign emit_fire  = emit_req && can_emit;
    assign flush_fire = (state_reg == S_FIN) && stg_valid_reg && out_free;
    assign adv = emit_req ? can_emit : ((state_reg == S_FIN) ? can_emit : 1'b1);

    // hold one word back so the last one of an item can be marked
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            stg_valid_reg <= 1'b0;
        end else begin
            if ((emit_fire && stg_valid_reg) || flush_fire) begin
                out_reg       <= stg_reg;
                out_last_reg  <= flush_fire;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (emit_fire) begin
                stg_reg       <= emit_data;
                stg_valid_reg <= 1'b1;
            end else if (flush_fire) begin
                stg_valid_reg <= 1'b0;
            end
        end
    end

    // take configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            errors_enabled_reg <= 1'b0;
            ack_enabled_reg    <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_ERRORS_ENABLED: errors_enabled_reg <= cfg_data;
                CFG_ACK_ENABLED:    ack_enabled_reg    <= cfg_data;
                default:            errors_enabled_reg <= errors_enabled_reg;
            endcase
        end
    end

    // latch the accepted word
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg    <= s_op;
            id_reg    <= s_frame_id;
            node_reg  <= s_node_index;
            rtr_reg   <= s_remote_request;
            rs_reg    <= s_was_resent;
            epos_reg  <= s_error_position;
            fbits_reg <= s_frame_bits;
            now_reg   <= s_time_now;
        end
    end

    // sequencer: state, flags, counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            ret_reg          <= S_FIN;
            bus_idle_reg     <= 1'b1;
            ack_received_reg <= 1'b1;
            state_ok_reg     <= 1'b1;
            err_latched_reg  <= 1'b0;
            err_pend_reg     <= '0;
            pos_valid_reg    <= 1'b0;
            cur_sit_reg      <= '0;
            count_reg        <= '0;
            scan_idx_reg     <= '0;
            switches_reg     <= '0;
        end else if (adv) begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        case (s_op)
                            OP_SIGNIN: state_reg <= S_SI_A;
                            OP_SIGNOUT: begin
                                rm_id_reg      <= s_frame_id;
                                rm_use_rtr_reg <= 1'b1;
                                rm_rtr_reg     <= s_remote_request;
                                ret_reg        <= S_FIN;
                                state_reg      <= S_REMOVE;
                            end
                            OP_ACK: begin
                                if (s_ack_bit) ack_received_reg <= 1'b1;
                                state_reg <= S_FIN;
                            end
                            OP_ERROR: state_reg <= S_ER_A;
                            OP_FRAME: state_reg <= S_FR_A;
                            OP_IDLE, OP_WAKE, OP_COMPLETE, OP_ERRRES,
                            OP_ERRRESDONE: state_reg <= S_OP_A;
                            default: state_reg <= S_FIN;
                        endcase
                    end
                end
                S_SI_A: begin
                    if (!table_full) count_reg <= count_reg + CW'(1);
                    state_reg <= S_SI_B;
                end
                S_SI_B: begin
                    if (bus_idle_reg) begin
                        ack_received_reg <= 1'b1;
                        bus_idle_reg     <= 1'b0;
                    end
                    state_reg <= S_FIN;
                end
                S_ER_A: begin
                    if (!err_latched_reg) begin
                        if (err_pend_reg != PEND_MAX) err_pend_reg <= err_pend_reg + 4'd1;
                        err_latched_reg <= 1'b1;
                    end
                    state_reg <= S_ER_B;
                end
                S_ER_B: begin
                    if (pos_upd) begin
                        pos_valid_reg <= 1'b1;
                        pos_value_reg <= epos_reg;
                    end
                    state_reg <= S_FIN;
                end
                S_FR_A: begin
                    ack_received_reg <= 1'b0;
                    state_reg <= S_FR_B;
                end
                S_FR_B: state_reg <= S_FIN;
                S_OP_A: begin
                    state_reg <= S_ARB_CHK;
                    case (op_reg)
                        OP_IDLE: begin
                            if (pend_clear || !errors_enabled_reg) begin
                                if (!ack_enabled_reg) begin
                                    state_ok_reg <= 1'b1;
                                end else if (ack_received_reg) begin
                                    state_ok_reg <= 1'b0;
                                end else begin
                                    state_reg <= S_OP_B;
                                end
                            end else begin
                                err_pend_reg <= err_pend_reg - 4'd1;
                            end
                        end
                        OP_COMPLETE: state_ok_reg <= 1'b1;
                        OP_ERRRES: begin
                            err_latched_reg <= 1'b0;
                            state_ok_reg    <= 1'b0;
                            pos_valid_reg   <= 1'b0;
                        end
                        OP_ERRRESDONE: begin
                            rm_id_reg      <= id_reg;
                            rm_use_rtr_reg <= 1'b0;
                            rm_rtr_reg     <= 1'b0;
                            ret_reg        <= S_OP_B;
                            state_reg      <= S_REMOVE;
                        end
                        default: state_reg <= S_ARB_CHK;
                    endcase
                end
                S_OP_B: state_reg <= S_ARB_CHK;
                S_ARB_CHK: begin
                    if (!arb_ok) begin
                        state_reg <= S_END;
                    end else if (count_reg == '0) begin
                        bus_idle_reg <= 1'b1;
                        state_reg    <= S_END;
                    end else begin
                        scan_idx_reg <= '0;
                        state_reg    <= S_MIN;
                    end
                end
                S_MIN: begin
                    if (scan_take) begin
                        best_id_reg   <= scan_e.id;
                        best_node_reg <= scan_e.node;
                        best_rs_reg   <= scan_e.rs;
                        best_sit_reg  <= scan_e.sit;
                    end
                    if (scan_idx_reg == last_idx) begin
                        scan_idx_reg <= '0;
                        switches_reg <= '0;
                        state_reg    <= S_CONF;
                    end else begin
                        scan_idx_reg <= scan_idx_reg + IW'(1);
                    end
                end
                S_CONF: begin
                    if (conf_take) begin
                        best_node_reg <= scan_e.node;
                        best_rs_reg   <= scan_e.rs;
                        best_sit_reg  <= scan_e.sit;
                        if (!switches_reg[1]) switches_reg <= switches_reg + 2'd1;
                    end
                    if (scan_idx_reg == last_idx) begin
                        rm_id_reg      <= best_id_reg;
                        rm_use_rtr_reg <= 1'b0;
                        rm_rtr_reg     <= 1'b0;
                        ret_reg        <= S_ARB_E1;
                        state_reg      <= S_REMOVE;
                    end else begin
                        scan_idx_reg <= scan_idx_reg + IW'(1);
                    end
                end
                S_REMOVE: begin
                    // drop the first hit each cycle until none is left
                    if (any_match) begin
                        count_reg <= count_reg - CW'(1);
                    end else begin
                        state_reg <= ret_reg;
                    end
                end
                S_ARB_E1: state_reg <= S_ARB_E2;
                S_ARB_E2: begin
                    cur_sit_reg <= best_sit_reg;
                    state_reg   <= S_END;
                end
                S_END: begin
                    ack_received_reg <= 1'b1;
                    state_reg <= S_FIN;
                end
                S_FIN: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_kind               = out_reg.kind;
    assign m_wake_event         = out_reg.wake;
    assign m_delay_bits         = out_reg.delay;
    assign m_target_node        = out_reg.node;
    assign m_result_id          = out_reg.id;
    assign m_grant_sign_in_time = out_reg.sit;
    assign m_grant_resent       = out_reg.rs;
    assign m_last_result        = out_last_reg;
endmodule
`default_nettype wire

// ===== hdl/can_arb_cell.sv =====
// One slot of the pending request chain: valid bit plus entry.
// Depends on can_arb_pkg. Takes its right neighbor's word while the chain compacts.
`default_nettype none
module can_arb_cell (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire can_arb_pkg::cell_ctrl_t ctrl,
    input  wire logic                  ins_en,
    input  wire can_arb_pkg::entry_t   ins_data,
    input  wire logic                  shift_in,
    input  wire logic                  nb_valid,
    input  wire can_arb_pkg::entry_t   nb_data,
    output logic                       q_valid,
    output can_arb_pkg::entry_t        q_data,
    output logic                       shift_out
);
    import can_arb_pkg::*;

    logic   valid_reg;
    entry_t data_reg;
    logic   match;

    // flag a live entry that hits the removal key
    assign match = valid_reg && (data_reg.id == ctrl.key_id) &&
                   (!ctrl.use_rtr || (data_reg.rtr == ctrl.key_rtr));
    assign shift_out = shift_in || match;

    // shift left past the first hit, or load a new entry at the tail
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.rm_en && shift_out) begin
            valid_reg <= nb_valid;
        end else if (ins_en) begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.rm_en && shift_out) begin
            data_reg <= nb_data;
        end else if (ins_en) begin
            data_reg <= ins_data;
        end
    end

    assign q_valid = valid_reg;
    assign q_data  = data_reg;
endmodule
`default_nettype wire

// ===== tb/tb_can_bus_arbitration_controller.sv =====
// Testbench for the CAN bus arbitration controller: directed table, then random events.
// Expected words come from an in-bench arbiter predictor; depends on can_arb_pkg.
`default_nettype none
module tb_can_bus_arbitration_controller;
    timeunit 1ns;
    timeprecision 1ps;
    import can_arb_pkg::*;

    localparam int DEPTH = 32;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   id;
        logic [NODE_W-1:0] node;
        logic              rtr;
        logic              rs;
        logic              ackb;
        logic [BITS_W-1:0] epos;
        logic [BITS_W-1:0] fbits;
        logic [TIME_W-1:0] now;
    } event_t;

    typedef struct packed {
        result_t r;
        logic    last;
    } word_t;

    typedef struct packed {
        logic    chk;
        event_t  e;
        word_t   w;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0, cfg_index = 1'b0, cfg_data = 1'b0;
    wire  cfg_ready;
    logic s_valid = 1'b0;
    wire  s_ready;
    event_t s_ev = '0;
    wire  m_valid;
    logic m_ready = 1'b0;
    wire [KIND_W-1:0] m_kind;
    wire [WAKE_W-1:0] m_wake_event;
    wire [BITS_W-1:0] m_delay_bits;
    wire [NODE_W-1:0] m_target_node;
    wire [ID_W-1:0]   m_result_id;
    wire [TIME_W-1:0] m_grant_sign_in_time;
    wire              m_grant_resent, m_last_result;

    can_bus_arbitration_controller dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_op(s_ev.op), .s_frame_id(s_ev.id), .s_node_index(s_ev.node),
        .s_remote_request(s_ev.rtr), .s_was_resent(s_ev.rs), .s_ack_bit(s_ev.ackb),
        .s_error_position(s_ev.epos), .s_frame_bits(s_ev.fbits), .s_time_now(s_ev.now),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_kind(m_kind), .m_wake_event(m_wake_event), .m_delay_bits(m_delay_bits),
        .m_target_node(m_target_node), .m_result_id(m_result_id),
        .m_grant_sign_in_time(m_grant_sign_in_time), .m_grant_resent(m_grant_resent),
        .m_last_result(m_last_result)
    );

    always #4 aclk = ~aclk;

    // predictor state
    entry_t      tbl [DEPTH];
    int          n_pend;
    bit          bus_idle, ack_rx, st_ok, err_latch, pos_ok, en_err, en_ack;
    int          err_cnt;
    logic [7:0]  pos_val;
    logic [31:0] cur_sit;
    word_t       step_words[$];
    word_t       expected_words[$];
    int          errors = 0;
    bit          no_idle = 1'b0;
    bit          hold_rx = 1'b0;

    function automatic void push_word(logic [3:0] k, logic [2:0] wk, logic [7:0] d,
                                      logic [4:0] nd, logic [28:0] id,
                                      logic [31:0] sit, logic rs);
        word_t w;
        w.r = '{kind: k, wake: wk, delay: d, node: nd, id: id, sit: sit, rs: rs};
        w.last = 1'b0;
        if (step_words.size() < 3) step_words.insert(step_words.size(), w);
    endfunction

    function automatic void drop_matching(logic [28:0] id, bit use_rtr, bit rtr);
        int i;
        i = 0;
        while (i < n_pend) begin
            if (tbl[i].id == id && (!use_rtr || tbl[i].rtr == rtr)) begin
                for (int j = i; j < n_pend - 1; j++) tbl[j] = tbl[j+1];
                n_pend--;
            end else begin
                i++;
            end
        end
    endfunction

    function automatic void pick_winner();
        int best, sw;
        entry_t win;
        if (n_pend == 0) begin
            bus_idle = 1;
            push_word(KIND_BUSIDLE, WK_IDLE, 0, 0, 0, 0, 0);
            return;
        end
        best = 0;
        sw = 0;
        for (int i = 1; i < n_pend; i++) if (tbl[i].id < tbl[best].id) best = i;
        win = tbl[best];
        for (int i = 0; i < n_pend; i++)
            if (tbl[i].id == win.id && !tbl[i].rtr && tbl[i].node != win.node) begin
                win.node = tbl[i].node;
                win.rs = tbl[i].rs;
                win.sit = tbl[i].sit;
                sw++;
            end
        drop_matching(win.id, 0, 0);
        cur_sit = win.sit;
        if (sw > 1) push_word(KIND_CONFLICT, WK_IDLE, 0, win.node, win.id, 0, 0);
        push_word(KIND_GRANT, WK_IDLE, 0, win.node, win.id, win.sit, win.rs);
    endfunction

    function automatic void arbiter_reset();
        n_pend = 0; bus_idle = 1; ack_rx = 1; st_ok = 1; err_latch = 0;
        err_cnt = 0; pos_ok = 0; pos_val = 0; cur_sit = 0; en_err = 0; en_ack = 1;
    endfunction

    // compute the words one event causes into step_words
    function automatic void predict_event(event_t e);
        logic [7:0] d;
        step_words.delete();
        case (e.op)
            OP_SIGNIN: begin
                if (n_pend < DEPTH) begin
                    tbl[n_pend] = '{id: e.id, node: e.node, rtr: e.rtr, rs: e.rs, sit: e.now};
                    n_pend++;
                end else begin
                    push_word(KIND_TABLEFULL, WK_IDLE, 0, e.node, e.id, 0, 0);
                end
                if (bus_idle) begin
                    ack_rx = 1; bus_idle = 0;
                    push_word(KIND_SCHEDULE, WK_WAKE, 1, e.node, e.id, 0, 0);
                end
            end
            OP_SIGNOUT: drop_matching(e.id, 1, e.rtr);
            OP_ACK: if (e.ackb) ack_rx = 1;
            OP_ERROR: begin
                if (!err_latch) begin
                    push_word(KIND_SCHEDULE, WK_ERRRES, ERROR_FRAME_BITS, e.node, e.id, 0, 0);
                    if (err_cnt < 15) err_cnt++;
                    err_latch = 1;
                end
                if (!pos_ok || pos_val > e.epos) begin
                    if (!pos_ok) push_word(KIND_FWDERROR, WK_IDLE, e.epos, e.node, e.id, 0, 0);
                    pos_ok = 1;
                    pos_val = e.epos;
                end
            end
            OP_FRAME: begin
                d = e.fbits;
                if (en_ack) d = (e.fbits > ACK_SLOT_BITS) ? e.fbits - ACK_SLOT_BITS : 8'd0;
                push_word(KIND_SCHEDULE, WK_IDLE, d, e.node, e.id, 0, 0);
                ack_rx = 0;
                push_word(KIND_FWDFRAME, WK_IDLE, e.fbits, e.node, e.id, 0, 0);
            end
            OP_IDLE, OP_WAKE, OP_COMPLETE, OP_ERRRES, OP_ERRRESDONE: begin
                if (e.op == OP_IDLE) begin
                    if (err_cnt == 0 || !en_err) begin
                        if (en_ack) begin
                            if (ack_rx) begin
                                push_word(KIND_SCHEDULE, WK_COMPLETE, ACK_SLOT_BITS,
                                          e.node, e.id, 0, 0);
                                st_ok = 0;
                            end else begin
                                push_word(KIND_FAILED, WK_IDLE, 0, e.node, e.id, 0, 0);
                                push_word(KIND_GRANT, WK_IDLE, 0, e.node, e.id, cur_sit, 1);
                            end
                        end else begin
                            push_word(KIND_COMPLETE, WK_IDLE, 0, e.node, e.id, 0, 0);
                            st_ok = 1;
                        end
                    end else begin
                        err_cnt--;
                    end
                end else if (e.op == OP_COMPLETE) begin
                    push_word(KIND_COMPLETE, WK_IDLE, 0, e.node, e.id, 0, 0);
                    st_ok = 1;
                end else if (e.op == OP_ERRRES) begin
                    push_word(KIND_SCHEDULE, WK_ERRRESDONE, pos_ok ? pos_val : NO_POS_DELAY,
                              e.node, e.id, 0, 0);
                    err_latch = 0; st_ok = 0; pos_ok = 0; pos_val = 0;
                end else if (e.op == OP_ERRRESDONE) begin
                    drop_matching(e.id, 0, 0);
                    push_word(KIND_GRANT, WK_IDLE, 0, e.node, e.id, cur_sit, 1);
                end
                if ((!en_err || err_cnt == 0) && (!en_ack || ack_rx) && st_ok) pick_winner();
                ack_rx = 1;
            end
            default: ;
        endcase
        if (step_words.size() > 0) step_words[step_words.size()-1].last = 1'b1;
    endfunction

    task automatic wait_cycles(int n);
        repeat (n) @(posedge aclk);
    endtask

    // drop valid for a random pause now and then
    task automatic sender_gap();
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            wait_cycles($urandom_range(1, 11));
        end
    endtask

    // offer one event, predict it once accepted; valid stays up for the next word
    task automatic send_event(event_t e);
        s_ev <= e;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_event(e);
        foreach (step_words[i]) expected_words.insert(expected_words.size(), step_words[i]);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (expected_words.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        wait_cycles(120);
    endtask

    task automatic write_reg(logic idx, logic val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_ERRORS_ENABLED) en_err = val; else en_ack = val;
        @(posedge aclk);
    endtask

    function automatic event_t mk(logic [3:0] op, logic [28:0] id, logic [4:0] nd,
                                  logic rtr, logic rs);
        event_t e;
        e = '0;
        e.op = op; e.id = id; e.node = nd; e.rtr = rtr; e.rs = rs;
        return e;
    endfunction

    function automatic event_t rand_event(int id_span);
        event_t e;
        int p;
        e.op = OP_SIGNIN;
        p = $urandom_range(0, 99);
        if (p < 30) e.op = OP_SIGNIN;
        else if (p < 38) e.op = OP_SIGNOUT;
        else if (p < 46) e.op = OP_ACK;
        else if (p < 54) e.op = OP_ERROR;
        else if (p < 62) e.op = OP_FRAME;
        else if (p < 96) e.op = 4'($urandom_range(5, 9));
        else e.op = 4'($urandom_range(10, 15));
        e.id = (id_span == 0) ? 29'($urandom) : 29'($urandom_range(0, id_span));
        e.node = 5'($urandom);
        e.rtr = 1'($urandom);
        e.rs = 1'($urandom);
        e.ackb = 1'($urandom);
        e.epos = 8'($urandom);
        e.fbits = 8'($urandom);
        e.now = $urandom;
        return e;
    endfunction

    // result side: random stalls, optional long hold-off
    initial begin
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_rx) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_rx = 1'b0;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // compare every accepted word with the oldest expectation
    always @(posedge aclk) begin
        word_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got.r = '{kind: m_kind, wake: m_wake_event, delay: m_delay_bits,
                      node: m_target_node, id: m_result_id, sit: m_grant_sign_in_time,
                      rs: m_grant_resent};
            got.last = m_last_result;
            if (expected_words.size() == 0) begin
                $display("%0t unexpected word: expected none, actual %h", $realtime, got);
                errors++;
            end else begin
                want = expected_words.pop_front();
                if (got !== want) begin
                    $display("%0t mismatch: expected %h, actual %h", $realtime, want, got);
                    errors++;
                end
            end
        end
    end

    // directed table; checked rows hold the word the event must produce first
    row_t rows[$];

    function automatic void add_row(logic chk, event_t e, word_t w);
        row_t r;
        r.chk = chk;
        r.e = e;
        r.w = w;
        rows.insert(rows.size(), r);
    endfunction

    initial begin
        event_t e;
        word_t w;
        arbiter_reset();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        e = mk(OP_IDLE, 0, 0, 0, 0);
        w.r = '{kind: KIND_SCHEDULE, wake: WK_COMPLETE, delay: ACK_SLOT_BITS, node: 0,
                id: 0, sit: 0, rs: 0};
        w.last = 1'b1;
        add_row(1'b1, e, w);
        add_row(1'b0, mk(OP_COMPLETE, 29'h1FFFFFFF, 31, 1, 1), '0);
        e = mk(OP_SIGNIN, 29'h1FFFFFFF, 31, 0, 1); e.now = 32'hFFFFFFFF;
        add_row(1'b0, e, '0);
        e = mk(OP_SIGNIN, 5, 1, 0, 0); e.now = 32'h0;
        add_row(1'b0, e, '0);
        add_row(1'b0, mk(OP_SIGNIN, 5, 2, 0, 1), '0);
        add_row(1'b0, mk(OP_SIGNIN, 5, 3, 0, 0), '0);
        add_row(1'b0, mk(OP_SIGNIN, 5, 4, 1, 0), '0);
        add_row(1'b0, mk(OP_SIGNIN, 0, 0, 1, 1), '0);
        add_row(1'b0, mk(OP_SIGNOUT, 0, 0, 1, 0), '0);
        add_row(1'b0, mk(OP_WAKE, 0, 0, 0, 0), '0);
        e = mk(OP_FRAME, 7, 7, 0, 0); e.fbits = 8'd5;
        add_row(1'b0, e, '0);
        add_row(1'b0, mk(OP_IDLE, 7, 7, 0, 0), '0);
        e = mk(OP_FRAME, 7, 7, 0, 0); e.fbits = 8'd255;
        add_row(1'b0, e, '0);
        e = mk(OP_ACK, 0, 0, 0, 0); e.ackb = 1;
        add_row(1'b0, e, '0);
        e = mk(OP_ERROR, 9, 9, 0, 0); e.epos = 8'd255;
        add_row(1'b0, e, '0);
        e = mk(OP_ERROR, 9, 9, 0, 0); e.epos = 8'd0;
        add_row(1'b0, e, '0);
        add_row(1'b0, mk(OP_ERRRES, 9, 9, 0, 0), '0);
        e = mk(OP_ERRRES, 9, 9, 0, 0);
        w.r = '{kind: KIND_SCHEDULE, wake: WK_ERRRESDONE, delay: NO_POS_DELAY, node: 9,
                id: 9, sit: 0, rs: 0};
        w.last = 1'b1;
        add_row(1'b1, e, w);
        add_row(1'b0, mk(OP_ERRRESDONE, 29'h1FFFFFFF, 3, 0, 0), '0);
        add_row(1'b0, mk(4'd15, 1, 1, 0, 0), '0);
        add_row(1'b0, mk(OP_COMPLETE, 0, 0, 0, 0), '0);

        // walk the table; checked rows are also compared directly with the predictor
        foreach (rows[i]) begin
            sender_gap();
            send_event(rows[i].e);
            if (rows[i].chk && (step_words.size() == 0 || step_words[0] !== rows[i].w)) begin
                $display("%0t directed row %0d: expected %h, actual %h", $realtime, i,
                         rows[i].w, step_words.size() ? step_words[0] : '0);
                errors++;
            end
        end
        drain();

        // fill the table past capacity under a long receiver hold-off
        write_reg(CFG_ACK_ENABLED, 1'b0);
        write_reg(CFG_ERRORS_ENABLED, 1'b1);
        hold_rx = 1'b1;
        for (int i = 0; i < DEPTH + 2; i++) begin
            e = rand_event(40); e.op = OP_SIGNIN;
            send_event(e);
        end
        for (int i = 0; i < 6; i++) begin
            e = rand_event(40); e.op = OP_WAKE;
            send_event(e);
        end
        drain();

        // random phases over every register setting
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_ERRORS_ENABLED, ph[0]);
            write_reg(CFG_ACK_ENABLED, ph[1]);
            for (int i = 0; i < 10; i++) begin
                if (ph == 3 && i == 5) no_idle = 1'b1;
                sender_gap();
                e = rand_event((i % 5 == 0) ? 0 : 15);
                send_event(e);
            end
            drain();
        end

        if (errors == 0 && expected_words.size() == 0)
            $display("tb_can_bus_arbitration_controller: PASS");
        else
            $display("tb_can_bus_arbitration_controller: FAIL");
        $finish;
    end

    initial begin
        #(2ms);
        $display("tb_can_bus_arbitration_controller: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/can_arb_pkg.sv
hdl/can_arb_cell.sv
hdl/can_bus_arbitration_controller.sv
tb/tb_can_bus_arbitration_controller.sv
